// ===== rtl/core/mrp_pkg.sv =====
// Package for the Modbus read response parser: types, constants and the CRC step.
package mrp_pkg;

    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [7:0]  FC_READ_HOLDING = 8'h03;
    localparam logic [8:0]  POS_MAX         = 9'd511;

    localparam logic [7:0]  SLAVE_ADDR_RESET = 8'd1;
    localparam logic [6:0]  WORD_LIMIT_RESET = 7'd127;

    localparam logic REG_SLAVE_ADDR = 1'b0;
    localparam logic REG_WORD_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_SHORT = 3'd1,
        ST_BAD_SLAVE = 3'd2,
        ST_BAD_FUNC  = 3'd3,
        ST_ODD_COUNT = 3'd4,
        ST_CRC_ERROR = 3'd5
    } mrp_status_t;

    typedef struct packed {
        logic        kind;
        logic [6:0]  reg_index;
        logic [15:0] reg_value;
        mrp_status_t status;
        logic [6:0]  reg_count;
    } mrp_result_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/mrp_frame_checker.sv =====
// Frame state, CRC and verdict logic for one received byte per cycle while accept is high.
module mrp_frame_checker
    import mrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,
    input  logic [7:0]  slave_addr,
    input  logic [6:0]  word_limit,
    output logic        result_valid,
    output mrp_result_t result
);

    logic [8:0]  pos_reg,      pos_next;
    logic [15:0] crc_reg,      crc_next;
    logic [7:0]  cnt_reg,      cnt_next;
    logic [7:0]  high_reg,     high_next;
    logic        slave_ok_reg, slave_ok_next;
    logic        func_ok_reg,  func_ok_next;
    logic [7:0]  crc_lo_reg,   crc_lo_next;
    logic        crc_ok_reg,   crc_ok_next;

    logic [9:0]  data_end;
    logic [7:0]  off;
    logic [6:0]  widx;
    logic        word;
    logic [9:0]  len;
    logic [6:0]  rc;
    mrp_status_t st;

    always_comb
    begin
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        cnt_next      = cnt_reg;
        high_next     = high_reg;
        slave_ok_next = slave_ok_reg;
        func_ok_next  = func_ok_reg;
        crc_lo_next   = crc_lo_reg;
        crc_ok_next   = crc_ok_reg;
        word          = 1'b0;
        data_end      = 10'd3 + {2'b00, cnt_reg};
        off           = pos_reg[7:0] - 8'd3;
        widx          = off[7:1];

        if (pos_reg == 9'd0)
        begin
            slave_ok_next = (rx_byte == slave_addr);
            crc_next      = crc16_byte(crc_reg, rx_byte);
        end
        else if (pos_reg == 9'd1)
        begin
            func_ok_next = (rx_byte == FC_READ_HOLDING);
            crc_next     = crc16_byte(crc_reg, rx_byte);
        end
        else if (pos_reg == 9'd2)
        begin
            cnt_next = rx_byte;
            crc_next = crc16_byte(crc_reg, rx_byte);
        end
        else if ({1'b0, pos_reg} < data_end)
        begin
            crc_next = crc16_byte(crc_reg, rx_byte);
            if (!off[0])
            begin
                high_next = rx_byte;
            end
            else
            begin
                word = (widx < word_limit);
            end
        end
        else if ({1'b0, pos_reg} == data_end)
        begin
            crc_lo_next = rx_byte;
        end
        else if ({1'b0, pos_reg} == data_end + 10'd1)
        begin
            crc_ok_next = (crc_reg == {rx_byte, crc_lo_reg});
        end

        if (pos_reg != POS_MAX)
        begin
            pos_next = pos_reg + 9'd1;
        end

        // verdict
        len = {1'b0, pos_reg} + 10'd1;
        rc  = 7'd0;
        priority if (len < 10'd5)
            st = ST_TOO_SHORT;
        else if (!slave_ok_next)
            st = ST_BAD_SLAVE;
        else if (!func_ok_next)
            st = ST_BAD_FUNC;
        else if (cnt_next[0])
            st = ST_ODD_COUNT;
        else if (len < 10'd5 + {2'b00, cnt_next})
            st = ST_TOO_SHORT;
        else if (!crc_ok_next)
            st = ST_CRC_ERROR;
        else
        begin
            st = ST_OK;
            rc = (cnt_next[7:1] > word_limit) ? word_limit : cnt_next[7:1];
        end

        if (frame_end)
        begin
            pos_next      = 9'd0;
            crc_next      = CRC_INIT;
            cnt_next      = 8'd0;
            high_next     = 8'd0;
            slave_ok_next = 1'b0;
            func_ok_next  = 1'b0;
            crc_lo_next   = 8'd0;
            crc_ok_next   = 1'b0;
        end

        result_valid = accept && (frame_end || word);
        if (frame_end)
        begin
            result.kind      = 1'b1;
            result.reg_index = 7'd0;
            result.reg_value = 16'd0;
            result.status    = st;
            result.reg_count = rc;
        end
        else
        begin
            result.kind      = 1'b0;
            result.reg_index = widx;
            result.reg_value = {high_reg, rx_byte};
            result.status    = ST_OK;
            result.reg_count = 7'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= 9'd0;
            crc_reg      <= CRC_INIT;
            cnt_reg      <= 8'd0;
            high_reg     <= 8'd0;
            slave_ok_reg <= 1'b0;
            func_ok_reg  <= 1'b0;
            crc_lo_reg   <= 8'd0;
            crc_ok_reg   <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            cnt_reg      <= cnt_next;
            high_reg     <= high_next;
            slave_ok_reg <= slave_ok_next;
            func_ok_reg  <= func_ok_next;
            crc_lo_reg   <= crc_lo_next;
            crc_ok_reg   <= crc_ok_next;
        end
    end

endmodule

// ===== rtl/core/modbus_read_response_parser_unit.sv =====
// Top level of the Modbus RTU read-holding-registers response parser.
// One received byte is taken per cycle while s_tready is high; its result (a
// provisional register word or, on the tlast byte, the frame verdict) goes to
// the output register, or to the second entry of a two-entry output buffer
// while one result waits there; s_tready drops only when both entries are
// full. Bytes that complete no word and end no frame give no result.
module modbus_read_response_parser_unit
    import mrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,   // frame_end
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [6:0] reg_index, [22:7] reg_value, [25:23] status,
                                   // [32:26] reg_count, [39:33] zero
    output logic        m_tlast    // kind: 0 register word, 1 verdict
);

    logic [7:0]  slave_addr_reg;
    logic [6:0]  word_limit_reg;

    logic        accept;
    logic        res_valid;
    mrp_result_t res;

    logic        out_valid_reg;
    mrp_result_t out_reg;
    logic        skid_valid_reg;
    mrp_result_t skid_reg;
    logic        pop;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= SLAVE_ADDR_RESET;
            word_limit_reg <= WORD_LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[2])
                REG_SLAVE_ADDR: slave_addr_reg <= pwdata[7:0];
                REG_WORD_LIMIT: word_limit_reg <= pwdata[6:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SLAVE_ADDR: prdata = {24'd0, slave_addr_reg};
            REG_WORD_LIMIT: prdata = {25'd0, word_limit_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    mrp_frame_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .rx_byte      (s_tdata),
        .frame_end    (s_tlast),
        .slave_addr   (slave_addr_reg),
        .word_limit   (word_limit_reg),
        .result_valid (res_valid),
        .result       (res)
    );

    assign pop = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.kind;
    assign m_tdata  = {7'd0, out_reg.reg_count, out_reg.status,
                       out_reg.reg_value, out_reg.reg_index};

endmodule

// ===== test/mrp_checker.sv =====
// Checker for the Modbus response parser: frame parse mirror, output and register compare.
`timescale 1ns / 100ps

package mrp_tb_pkg;

    function automatic logic [15:0] crc_update(input logic [15:0] acc, input logic [7:0] data);
        logic [15:0] r;
        r = acc;
        for (int i = 0; i < 8; i++)
        begin
            if (r[0] ^ data[i])
                r = (r >> 1) ^ mrp_pkg::CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

endpackage

module mrp_checker
    import mrp_pkg::*;
    import mrp_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tlast,
    output int          errors,
    output int          pending
);

    logic [7:0]  slave_id;
    logic [6:0]  reg_limit;

    logic [8:0]  frame_pos;
    logic [15:0] crc_run;
    logic [7:0]  data_len;
    logic [7:0]  hi_byte;
    logic [7:0]  crc_lo_rx;
    logic        addr_hit;
    logic        fc_hit;
    logic        crc_hit;

    mrp_result_t words_due[$];

    task automatic clear_parse();
        frame_pos = '0;
        crc_run   = CRC_INIT;
        data_len  = '0;
        hi_byte   = '0;
        crc_lo_rx = '0;
        addr_hit  = 1'b0;
        fc_hit    = 1'b0;
        crc_hit   = 1'b0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic fin);
        int          p;
        int          off;
        int          len;
        bit          word_done;
        mrp_result_t r;
        p         = frame_pos;
        word_done = 1'b0;
        r         = '0;
        r.status  = ST_OK;
        if (p == 0)
        begin
            addr_hit = (b == slave_id);
            crc_run  = crc_update(crc_run, b);
        end
        else if (p == 1)
        begin
            fc_hit  = (b == FC_READ_HOLDING);
            crc_run = crc_update(crc_run, b);
        end
        else if (p == 2)
        begin
            data_len = b;
            crc_run  = crc_update(crc_run, b);
        end
        else if (p < 3 + data_len)
        begin
            off     = p - 3;
            crc_run = crc_update(crc_run, b);
            if (off % 2 == 0)
                hi_byte = b;
            else
            begin
                r.reg_index = 7'(off / 2);
                r.reg_value = {hi_byte, b};
                word_done   = (off / 2) < reg_limit;
            end
        end
        else if (p == 3 + data_len)
            crc_lo_rx = b;
        else if (p == 4 + data_len)
            crc_hit = (crc_run == {b, crc_lo_rx});

        if (frame_pos != POS_MAX)
            frame_pos = frame_pos + 9'd1;

        if (fin)
        begin
            len         = p + 1;
            r           = '0;
            r.kind      = 1'b1;
            if (len < 5)
                r.status = ST_TOO_SHORT;
            else if (!addr_hit)
                r.status = ST_BAD_SLAVE;
            else if (!fc_hit)
                r.status = ST_BAD_FUNC;
            else if (data_len[0])
                r.status = ST_ODD_COUNT;
            else if (len < 5 + data_len)
                r.status = ST_TOO_SHORT;
            else if (!crc_hit)
                r.status = ST_CRC_ERROR;
            else
            begin
                r.status    = ST_OK;
                r.reg_count = (data_len[7:1] > reg_limit) ? reg_limit : data_len[7:1];
            end
            words_due.push_back(r);
            clear_parse();
        end
        else if (word_done)
            words_due.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mrp_result_t want;
        logic [31:0] reg_val;
        logic [40:0] want_bits;
        if (!rst_n)
        begin
            slave_id  = SLAVE_ADDR_RESET;
            reg_limit = WORD_LIMIT_RESET;
            clear_parse();
            words_due.delete();
            errors    = 0;
            pending   = 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                reg_val = (paddr == {REG_SLAVE_ADDR, 2'b00}) ? {24'd0, slave_id}
                                                            : {25'd0, reg_limit};
                if (pwrite)
                begin
                    if (paddr == {REG_SLAVE_ADDR, 2'b00})
                        slave_id = pwdata[7:0];
                    else if (paddr == {REG_WORD_LIMIT, 2'b00})
                        reg_limit = pwdata[6:0];
                end
                else if (prdata !== reg_val)
                begin
                    errors++;
                    $display("%0t: register read at %0d, expected %h, got %h",
                             $time, paddr, reg_val, prdata);
                end
            end

            if (m_tvalid && m_tready)
            begin
                if (words_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word, expected none, got kind=%0d data=%h",
                             $time, m_tlast, m_tdata);
                end
                else
                begin
                    want      = words_due.pop_front();
                    want_bits = {want.kind, 7'd0, want.reg_count, want.status,
                                 want.reg_value, want.reg_index};
                    if ({m_tlast, m_tdata} !== want_bits)
                    begin
                        errors++;
                        $display("%0t: word mismatch, expected %h, got %h",
                                 $time, want_bits, {m_tlast, m_tdata});
                    end
                end
            end

            if (s_tvalid && s_tready)
                parse_byte(s_tdata, s_tlast);

            pending = words_due.size();
        end
    end

endmodule

// ===== test/modbus_read_response_parser_unit_tb.sv =====
// Testbench top for the Modbus response parser: frame stimulus, register setup and verdict.
`timescale 1ns / 100ps

module modbus_read_response_parser_unit_tb;
    import mrp_pkg::*;
    import mrp_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    wire  [31:0] prdata;
    wire         pready;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [39:0] m_tdata;
    wire         m_tlast;
    int          errors;
    int          pending;

    logic [7:0]  cur_slave      = SLAVE_ADDR_RESET;
    int          bytes_sent     = 0;
    int          src_gap_pct    = 30;
    int          sink_stall_pct = 30;
    bit          hold_off_go    = 1'b0;
    int          idle_cycles    = 0;
    int          stall          = 0;
    logic [7:0]  frame[$];

    always #10 clk = ~clk;

    modbus_read_response_parser_unit dut (.*);

    mrp_checker u_checker (.*);

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        if ($urandom_range(99) < src_gap_pct)
            gap = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(3, 1);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame[i])
            send_byte(frame[i], i == frame.size() - 1);
    endtask

    task automatic add_crc(input logic [15:0] flip);
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame[i])
            c = crc_update(c, frame[i]);
        c = c ^ flip;
        frame.push_back(c[7:0]);
        frame.push_back(c[15:8]);
    endtask

    // mostly well-formed frames, the rest broken in one way each
    task automatic build_frame();
        int pick;
        int cnt;
        pick = $urandom_range(99);
        cnt  = $urandom_range(12, 0);
        cnt  = (pick >= 69 && pick < 76) ? (cnt | 1) : (cnt & 'hFE);
        frame.delete();
        if (pick >= 92)
        begin
            repeat ($urandom_range(8, 1))
                frame.push_back(8'($urandom));
        end
        else
        begin
            frame.push_back((pick >= 55 && pick < 62) ?
                            cur_slave ^ 8'($urandom_range(255, 1)) : cur_slave);
            frame.push_back((pick >= 62 && pick < 69) ?
                            FC_READ_HOLDING ^ 8'($urandom_range(255, 1)) : FC_READ_HOLDING);
            frame.push_back(8'(cnt));
            repeat (cnt)
                frame.push_back(8'($urandom));
            add_crc((pick >= 76 && pick < 84) ? 16'($urandom_range(65535, 1)) : 16'd0);
            if (pick >= 84)
                repeat ($urandom_range(frame.size() - 1, 1))
                    void'(frame.pop_back());
            else if (pick < 55 && $urandom_range(3) == 0)
                repeat ($urandom_range(3, 1))
                    frame.push_back(8'($urandom));
        end
    endtask

    task automatic run_frames(input int budget, input int gap_pct, input int stall_pct);
        int start;
        start          = bytes_sent;
        src_gap_pct    = gap_pct;
        sink_stall_pct = stall_pct;
        while (bytes_sent - start < budget)
        begin
            build_frame();
            send_frame();
        end
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] slave, input logic [6:0] limit);
        drain();
        apb_access(1'b1, {REG_SLAVE_ADDR, 2'b00}, {24'd0, slave});
        apb_access(1'b1, {REG_WORD_LIMIT, 2'b00}, {25'd0, limit});
        apb_access(1'b0, {REG_SLAVE_ADDR, 2'b00}, '0);
        apb_access(1'b0, {REG_WORD_LIMIT, 2'b00}, '0);
        cur_slave = slave;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall > 0)
                stall--;
            else if (hold_off_go)
            begin
                hold_off_go = 1'b0;
                stall       = HOLD_CYCLES;
            end
            else if ($urandom_range(99) < sink_stall_pct)
                stall = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(3, 1);
            m_tready <= (stall == 0);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: full-range data, word on the last byte, exception reply,
        // single byte, odd count
        frame = '{8'h01, FC_READ_HOLDING, 8'h04, 8'hFF, 8'h00, 8'h00, 8'hFF};
        add_crc(16'd0);
        send_frame();
        frame = '{8'h01, FC_READ_HOLDING, 8'h02, 8'hAA, 8'h55};
        send_frame();
        frame = '{8'h01, 8'h83, 8'h02};
        add_crc(16'd0);
        send_frame();
        frame = '{8'hFF};
        send_frame();
        frame = '{8'h01, FC_READ_HOLDING, 8'h01, 8'h7E};
        add_crc(16'd0);
        send_frame();

        set_config(8'h00, 7'd0);
        run_frames(30, 0, 0);

        set_config(8'hFF, 7'd127);
        run_frames(30, 50, 40);

        set_config(8'($urandom), 7'($urandom_range(6, 1)));
        run_frames(30, 30, 30);

        // long frame under a receiver hold-off: full byte count, then trailing
        // bytes past the point where the position counter saturates
        set_config(8'($urandom), 7'($urandom_range(127, 8)));
        frame.delete();
        frame = '{cur_slave, FC_READ_HOLDING, 8'd254};
        repeat (254)
            frame.push_back(8'($urandom));
        add_crc(16'd0);
        while (frame.size() < 516)
            frame.push_back(8'($urandom));
        src_gap_pct    = 0;
        sink_stall_pct = 20;
        hold_off_go    = 1'b1;
        send_frame();
        run_frames(30, 40, 50);

        drain();
        repeat (6) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
